/* rtl/lpc_pkg.sv */
// Shared types, sizes and helpers for the LRU page cache hit counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int PAGE_W      = 32;
  localparam int CFG_W       = 5;
  localparam int TOTAL_W     = 32;
  localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);

  localparam logic [CFG_W-1:0] CACHE_SIZE_RESET = CFG_W'(16);

  // Per-cell control from the top level.
  typedef struct packed {
    logic valid;  // entry lies below the fill count in use
    logic shift;  // load the neighbor's page this cycle
  } cell_ctl_t;

  // Capacity in use: zero acts as one, above MAX_ENTRIES saturates.
  function automatic logic [FILL_W-1:0] cap_of(input logic [CFG_W-1:0] size);
    logic [FILL_W-1:0] cap;
    if (int'(size) > MAX_ENTRIES) begin
      cap = FILL_W'(MAX_ENTRIES);
    end else if (size == '0) begin
      cap = FILL_W'(1);
    end else begin
      cap = FILL_W'(size);
    end
    return cap;
  endfunction

endpackage

`default_nettype wire

/* rtl/lru_page_cache_hit_counter_top.sv */
// Top level of the LRU page cache hit counter: row of lpc_cell entries,
// fill count, hit total and output register. Depends on lpc_pkg, lpc_cell.
//
// Usage:
//   Requests arrive on page_number with in_valid/in_ready; a transfer is
//   taken when both are high. Each request yields exactly one result
//   (hit, hit_total) on out_valid/out_ready.
//   The result is registered and shows in the cycle after the input
//   transfer. Throughput: one request per cycle while out_ready holds;
//   every cell compares and shifts in the same cycle, so the row of
//   cells sets the rate. When the receiver stalls, the result holds and
//   in_ready drops until the result transfers; a request can be taken in
//   the same cycle the held result leaves. cache_size is written through
//   cfg_we/cfg_wdata; the user must write it only while idle, which the
//   block does not enforce. It resets to 16. Reset clears the fill count,
//   hit total and out_valid; entries are not cleared and read empty until filled.
`default_nettype none

module lru_page_cache_hit_counter_top
  import lpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PAGE_W-1:0]  page_number,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic [TOTAL_W-1:0]      hit_total,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  logic [CFG_W-1:0]   cache_size;
  logic [FILL_W-1:0]  fill_count;
  logic [FILL_W-1:0]  fill_count_next;
  logic [FILL_W-1:0]  cap;
  logic [FILL_W-1:0]  fill_eff;
  logic [FILL_W-1:0]  fill_miss;
  logic [TOTAL_W-1:0] hit_counter;
  logic               accept;
  logic               hit_now;

  cell_ctl_t          ctl   [MAX_ENTRIES];
  logic [PAGE_W-1:0]  pages [MAX_ENTRIES];
  logic [PAGE_W-1:0]  prev  [MAX_ENTRIES];
  logic [MAX_ENTRIES:0] chain;
  logic [MAX_ENTRIES-1:0] match_vec;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign hit_total = hit_counter;

  // Shrinking capacity drops the back entries before the lookup.
  assign cap       = cap_of(cache_size);
  assign fill_eff  = (fill_count > cap) ? cap : fill_count;
  assign fill_miss = (fill_eff < cap) ? fill_eff + FILL_W'(1) : fill_eff;
  assign hit_now   = chain[0];
  assign fill_count_next = hit_now ? fill_eff : fill_miss;

  assign chain[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = page_number;
    end else begin : g_body
      assign prev[i] = pages[i-1];
    end

    always_comb begin
      ctl[i].valid = FILL_W'(i) < fill_eff;
      // Head always takes the request; others shift up to the hit or the new fill.
      if (i == 0) begin
        ctl[i].shift = accept;
      end else if (hit_now) begin
        ctl[i].shift = accept && chain[i];
      end else begin
        ctl[i].shift = accept && (FILL_W'(i) < fill_miss);
      end
    end

    lpc_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .page_number (page_number),
      .prev_page   (prev[i]),
      .hit_in      (chain[i+1]),
      .page        (pages[i]),
      .match       (match_vec[i]),
      .hit_out     (chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_size  <= CACHE_SIZE_RESET;
      fill_count  <= '0;
      hit_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_size <= cfg_wdata;
      end
      if (accept) begin
        fill_count <= fill_count_next;
        if (hit_now) begin
          hit_counter <= hit_counter + TOTAL_W'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit <= hit_now;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(MAX_ENTRIES))
    else $error("fill count above capacity");

  a_unique_pages: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("page resident in more than one entry");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> hit_total == $past(hit_total) + TOTAL_W'(hit))
    else $error("hit total out of step with hit flag");

  a_miss_fills: assert property (@(posedge clk) disable iff (rst)
    accept && !hit_now |=> fill_count != '0)
    else $error("miss left the cache empty");
`endif

endmodule

`default_nettype wire

/* rtl/lpc_cell.sv */
// One entry of the recency stack: holds a page, compares it to the request
// and takes its neighbor's page when told to shift. Depends on lpc_pkg.
`default_nettype none

module lpc_cell
  import lpc_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [PAGE_W-1:0] page_number,
  input  wire logic [PAGE_W-1:0] prev_page,
  input  wire logic              hit_in,
  output logic [PAGE_W-1:0]      page,
  output logic                   match,
  output logic                   hit_out
);

  assign match   = ctl.valid && (page == page_number);
  // Hit at this cell or anywhere behind it.
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      page <= prev_page;
    end
  end

endmodule

`default_nettype wire
